/* hdl/scrb_pkg.sv */
// Shared types, constants and decode helpers for the SPI controller register block.
// Used by every module under hdl/ except scrb_ram; depends on nothing.
package scrb_pkg;

  // Receive FIFO and register window sizing
  localparam int RX_DEPTH = 32;
  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int RX_LW = $clog2(RX_DEPTH + 1);
  localparam int REG_WINDOW_BYTES = 288;
  localparam int REG_WORDS = REG_WINDOW_BYTES / 4;
  localparam int WORD_W = $clog2(REG_WORDS);
  localparam int ADDR_W = 12;

  // Decode queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int Q_CW = $clog2(Q_DEPTH + 1);

  // Register word indexes
  localparam logic [WORD_W-1:0] W_CTRLR0   = WORD_W'(0);
  localparam logic [WORD_W-1:0] W_SSIENR   = WORD_W'(2);
  localparam logic [WORD_W-1:0] W_SER      = WORD_W'(4);
  localparam logic [WORD_W-1:0] W_BAUDR    = WORD_W'(5);
  localparam logic [WORD_W-1:0] W_TXFTLR   = WORD_W'(6);
  localparam logic [WORD_W-1:0] W_RXFTLR   = WORD_W'(7);
  localparam logic [WORD_W-1:0] W_TXFLR    = WORD_W'(8);
  localparam logic [WORD_W-1:0] W_RXFLR    = WORD_W'(9);
  localparam logic [WORD_W-1:0] W_SR       = WORD_W'(10);
  localparam logic [WORD_W-1:0] W_IMR      = WORD_W'(11);
  localparam logic [WORD_W-1:0] W_ISR      = WORD_W'(12);
  localparam logic [WORD_W-1:0] W_RISR     = WORD_W'(13);
  localparam logic [WORD_W-1:0] W_VERSION  = WORD_W'(23);
  localparam logic [WORD_W-1:0] W_DR_FIRST = WORD_W'(24);
  localparam logic [WORD_W-1:0] W_DR_LAST  = WORD_W'(59);
  localparam logic [WORD_W-1:0] W_XIP_INCR = WORD_W'(64);

  // Reset and fixed values
  localparam logic [31:0] CTRLR0_RESET   = 32'h0000_4007;
  localparam logic [31:0] BAUDR_RESET    = 32'h0000_0002;
  localparam logic [15:0] XIP_RESET      = 16'h0003;
  localparam logic [31:0] VERSION_VALUE  = 32'h3130_332a;
  localparam logic [3:0]  SEL_COUNT_RESET = 4'd1;
  localparam logic [3:0]  SEL_LINES      = 4'd8;

  // Plain read/write words live in a small slot array
  localparam int PLAIN_SLOTS = 17;
  localparam int PLAIN_AW = $clog2(PLAIN_SLOTS);
  localparam logic [PLAIN_AW-1:0] SLOT_CTRLR0 = PLAIN_AW'(0);
  localparam logic [PLAIN_AW-1:0] SLOT_BAUDR  = PLAIN_AW'(3);
  localparam logic [PLAIN_AW-1:0] SLOT_IMR    = PLAIN_AW'(4);

  typedef enum logic [2:0] {
    K_BAD    = 3'd0,
    K_DR_WR  = 3'd1,
    K_DR_RD  = 3'd2,
    K_REG_RD = 3'd3,
    K_REG_WR = 3'd4
  } kind_e;

  typedef struct packed {
    logic                hit;
    logic [PLAIN_AW-1:0] slot;
  } plain_t;

  // One classified bus access
  typedef struct packed {
    kind_e               kind;
    logic [WORD_W-1:0]   word;
    plain_t              plain;
    logic [31:0]         wdata;
    logic [7:0]          rx_byte;
  } item_t;

  // Queue status toward the back end
  typedef struct packed {
    logic nonempty;
    logic full;
  } q_stat_t;

  // Map a word index to its plain slot
  function automatic plain_t plain_lookup(input logic [WORD_W-1:0] word);
    plain_t p;
    p.hit = 1'b1;
    case (word)
      WORD_W'(0):  p.slot = PLAIN_AW'(0);
      WORD_W'(1):  p.slot = PLAIN_AW'(1);
      WORD_W'(3):  p.slot = PLAIN_AW'(2);
      WORD_W'(5):  p.slot = PLAIN_AW'(3);
      WORD_W'(11): p.slot = PLAIN_AW'(4);
      WORD_W'(19): p.slot = PLAIN_AW'(5);
      WORD_W'(20): p.slot = PLAIN_AW'(6);
      WORD_W'(21): p.slot = PLAIN_AW'(7);
      WORD_W'(60): p.slot = PLAIN_AW'(8);
      WORD_W'(61): p.slot = PLAIN_AW'(9);
      WORD_W'(62): p.slot = PLAIN_AW'(10);
      WORD_W'(63): p.slot = PLAIN_AW'(11);
      WORD_W'(65): p.slot = PLAIN_AW'(12);
      WORD_W'(66): p.slot = PLAIN_AW'(13);
      WORD_W'(67): p.slot = PLAIN_AW'(14);
      WORD_W'(69): p.slot = PLAIN_AW'(15);
      WORD_W'(70): p.slot = PLAIN_AW'(16);
      default: begin
        p.hit  = 1'b0;
        p.slot = '0;
      end
    endcase
    return p;
  endfunction

  function automatic logic [31:0] plain_reset(input logic [PLAIN_AW-1:0] slot);
    logic [31:0] v;
    v = '0;
    if (slot == SLOT_CTRLR0) v = CTRLR0_RESET;
    if (slot == SLOT_BAUDR) v = BAUDR_RESET;
    return v;
  endfunction

endpackage

/* hdl/scrb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module scrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/scrb_front.sv */
// Front end: checks the offset and classifies each bus access into an item_t.
// Depends on scrb_pkg.
module scrb_front import scrb_pkg::*; (
  input  logic              req_type_i,
  input  logic [ADDR_W-1:0] byte_addr_i,
  input  logic [31:0]       write_data_i,
  input  logic [7:0]        spi_rx_byte_i,
  output item_t             item_o
);

  logic              bad;
  logic              is_dr;
  logic [WORD_W-1:0] word;

  // misaligned or past the window
  assign bad  = (byte_addr_i[1:0] != 2'b00) ||
                ({1'b0, byte_addr_i} >= (ADDR_W + 1)'(REG_WINDOW_BYTES));
  assign word = byte_addr_i[WORD_W+1:2];
  assign is_dr = (word >= W_DR_FIRST) && (word <= W_DR_LAST);

  always_comb begin
    item_o.word    = word;
    item_o.plain   = plain_lookup(word);
    item_o.wdata   = write_data_i;
    item_o.rx_byte = spi_rx_byte_i;
    if (bad) begin
      item_o.kind = K_BAD;
    end else if (is_dr) begin
      item_o.kind = req_type_i ? K_DR_WR : K_DR_RD;
    end else begin
      item_o.kind = req_type_i ? K_REG_WR : K_REG_RD;
    end
  end

endmodule

/* hdl/scrb_queue.sv */
// Short queue of classified items between front and back end.
// Depends on scrb_pkg.
module scrb_queue import scrb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  item_t   item_i,
  input  logic    pop_i,
  output item_t   item_o,
  output q_stat_t stat_o
);

  item_t           slot_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [Q_CW-1:0] count_q, count_d;

  assign stat_o.nonempty = (count_q != '0);
  assign stat_o.full     = (count_q == Q_CW'(Q_DEPTH));
  assign item_o          = slot_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    else if (!push_i && pop_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= item_i;
  end

endmodule

/* hdl/scrb_back.sv */
// Back end: register file, receive FIFO, select logic and the output register.
// Depends on scrb_pkg and scrb_ram.
module scrb_back import scrb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  item_t            item_i,
  input  q_stat_t          q_stat_i,
  output logic             pop_o,
  input  logic [3:0]       select_count_i,
  output logic [RX_LW-1:0] rx_level_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [31:0]      read_data_o,
  output logic             spi_tx_valid_o,
  output logic [7:0]       spi_tx_byte_o,
  output logic [7:0]       select_lines_n_o,
  output logic             irq_out_o,
  output logic             bad_access_o
);

  // register state
  logic [31:0]      plain_q [PLAIN_SLOTS];
  logic [4:0]       txftlr_q, txftlr_d, rxftlr_q, rxftlr_d;
  logic [15:0]      xip_q, xip_d;
  logic [7:0]       ser_q, ser_d;
  logic             en_q, en_d;
  logic             sel_act_q, sel_act_d;
  logic [2:0]       sel_idx_q, sel_idx_d;
  logic [RX_AW-1:0] head_q, head_d;
  logic [RX_LW-1:0] level_q, level_d;
  logic             plain_we;
  logic [31:0]      imr_d;

  // output register
  logic        out_valid_q, out_pop_q, out_txv_q, out_irq_q, out_bad_q;
  logic [31:0] out_rd_q, rd_d;
  logic [7:0]  out_txb_q, out_sel_q, txb_d, sel_lines_d;
  logic        txv_d, irq_d, pop_d;

  // FIFO RAM access
  logic             ram_we, ram_re;
  logic [RX_AW-1:0] ram_waddr;
  logic [7:0]       ram_rdata;
  logic [RX_LW:0]   tail_sum;
  logic [3:0]       cnt;
  logic [7:0]       lowest;
  logic [2:0]       low_idx;

  logic exec;
  assign exec  = q_stat_i.nonempty && (!out_valid_q || !out_stall_i);
  assign pop_o = exec;

  assign cnt = (select_count_i > SEL_LINES) ? SEL_LINES : select_count_i;

  // FIFO tail position, wraps at the depth
  assign tail_sum = {1'b0, {(RX_LW - RX_AW){1'b0}}, head_q} + {1'b0, level_q};
  assign ram_waddr = (tail_sum >= (RX_LW + 1)'(RX_DEPTH)) ?
                     RX_AW'(tail_sum - (RX_LW + 1)'(RX_DEPTH)) : RX_AW'(tail_sum);

  // lowest set select bit of the next SER value
  always_comb begin
    low_idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (ser_d[i]) low_idx = 3'(i);
    end
  end
  assign lowest = ser_d;

  // execute one item
  always_comb begin
    txftlr_d  = txftlr_q;
    rxftlr_d  = rxftlr_q;
    xip_d     = xip_q;
    ser_d     = ser_q;
    en_d      = en_q;
    head_d    = head_q;
    level_d   = level_q;
    plain_we  = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    rd_d      = '0;
    txv_d     = 1'b0;
    txb_d     = '0;
    pop_d     = 1'b0;
    imr_d     = plain_q[SLOT_IMR];
    if (exec) begin
      unique case (item_i.kind)
        K_BAD: ;
        K_DR_WR: begin
          if (en_q && sel_act_q) begin
            txv_d = 1'b1;
            txb_d = item_i.wdata[7:0];
            if (level_q < RX_LW'(RX_DEPTH)) begin
              ram_we  = 1'b1;
              level_d = level_q + 1'b1;
            end
          end
        end
        K_DR_RD: begin
          if (level_q != '0) begin
            ram_re  = 1'b1;
            pop_d   = 1'b1;
            head_d  = (head_q == RX_AW'(RX_DEPTH - 1)) ? '0 : head_q + 1'b1;
            level_d = level_q - 1'b1;
          end
        end
        K_REG_RD: begin
          if (item_i.plain.hit) begin
            rd_d = plain_q[item_i.plain.slot];
          end else begin
            case (item_i.word)
              W_SSIENR:   rd_d = {31'b0, en_q};
              W_SER:      rd_d = {24'b0, ser_q};
              W_TXFTLR:   rd_d = {27'b0, txftlr_q};
              W_RXFTLR:   rd_d = {27'b0, rxftlr_q};
              W_RXFLR:    rd_d = 32'(level_q);
              W_SR:       rd_d = {27'b0, level_q == RX_LW'(RX_DEPTH),
                                  level_q != '0, 2'b11, 1'b0};
              W_RISR:     rd_d = {27'b0, level_q > RX_LW'(rxftlr_q), 4'b0001};
              W_ISR:      rd_d = {27'b0, (level_q > RX_LW'(rxftlr_q)) & imr_d[4],
                                  3'b000, imr_d[0]};
              W_VERSION:  rd_d = VERSION_VALUE;
              W_XIP_INCR: rd_d = {16'b0, xip_q};
              default:    rd_d = '0;
            endcase
          end
        end
        K_REG_WR: begin
          if (item_i.plain.hit) begin
            plain_we = 1'b1;
            if (item_i.plain.slot == SLOT_IMR) imr_d = item_i.wdata;
          end else begin
            case (item_i.word)
              W_TXFTLR:   txftlr_d = item_i.wdata[4:0];
              W_RXFTLR:   rxftlr_d = item_i.wdata[4:0];
              W_XIP_INCR: xip_d    = item_i.wdata[15:0];
              W_SER: begin
                for (int i = 0; i < 8; i++) begin
                  ser_d[i] = item_i.wdata[i] & (4'(i) < cnt);
                end
              end
              W_SSIENR:   en_d = item_i.wdata[0];
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // select follows SER and SSIENR writes only
  logic sel_update;
  assign sel_update = exec && (item_i.kind == K_REG_WR) &&
                      ((item_i.word == W_SER) || (item_i.word == W_SSIENR));

  always_comb begin
    sel_act_d = sel_act_q;
    sel_idx_d = sel_idx_q;
    if (sel_update) begin
      if (!en_d || (lowest == '0) || ({1'b0, low_idx} >= cnt)) begin
        sel_act_d = 1'b0;
      end else begin
        sel_act_d = 1'b1;
        sel_idx_d = low_idx;
      end
    end
  end

  // status after the access
  assign sel_lines_d = sel_act_d ? ~(8'b1 << sel_idx_d) : 8'hff;
  assign irq_d = imr_d[0] | ((level_d > RX_LW'(rxftlr_d)) & imr_d[4]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < PLAIN_SLOTS; s++) begin
        plain_q[s] <= plain_reset(PLAIN_AW'(s));
      end
      txftlr_q  <= '0;
      rxftlr_q  <= '0;
      xip_q     <= XIP_RESET;
      ser_q     <= '0;
      en_q      <= 1'b0;
      sel_act_q <= 1'b0;
      sel_idx_q <= '0;
      head_q    <= '0;
      level_q   <= '0;
    end else begin
      if (plain_we) plain_q[item_i.plain.slot] <= item_i.wdata;
      txftlr_q  <= txftlr_d;
      rxftlr_q  <= rxftlr_d;
      xip_q     <= xip_d;
      ser_q     <= ser_d;
      en_q      <= en_d;
      sel_act_q <= sel_act_d;
      sel_idx_q <= sel_idx_d;
      head_q    <= head_d;
      level_q   <= level_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_pop_q <= pop_d;
      out_rd_q  <= rd_d;
      out_txv_q <= txv_d;
      out_txb_q <= txb_d;
      out_sel_q <= sel_lines_d;
      out_irq_q <= irq_d;
      out_bad_q <= (item_i.kind == K_BAD);
    end
  end

  scrb_ram #(
    .WIDTH (8),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (item_i.rx_byte),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // popped byte comes straight from the RAM read register
  assign read_data_o      = out_pop_q ? {24'b0, ram_rdata} : out_rd_q;
  assign out_valid_o      = out_valid_q;
  assign spi_tx_valid_o   = out_txv_q;
  assign spi_tx_byte_o    = out_txb_q;
  assign select_lines_n_o = out_sel_q;
  assign irq_out_o        = out_irq_q;
  assign bad_access_o     = out_bad_q;
  assign rx_level_o       = level_q;

endmodule

/* hdl/spi_controller_register_block.sv */
// Top level of the SPI controller register block: front decode, item queue, back end.
// Depends on scrb_pkg, scrb_front, scrb_queue, scrb_back.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------------
//  in      | input     | in_valid_i/in_stall_o | req_type, byte_addr, write_data, spi_rx_byte
//  out     | output    | out_valid_o/out_stall_i | read_data, spi_tx_*, select_lines_n, irq,
//          |           |                       | bad_access
//  cfg     | input     | cfg_valid_i/cfg_ready_o | select count (4 bits)
//
// One item per cycle sustained while the output is not stalled; an accepted item waits
// in the decode queue and is then executed into the output register, which drives
// out_valid_o. The single back-end execute stage updates the FIFO pointers and register
// file for each executed item. The receive RAM read port supplies popped bytes.
// Reset clears all control state and restores register defaults; no clearing pass.
// The input stalls only when the two-entry queue is full behind a stalled output.
module spi_controller_register_block import scrb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              req_type_i,
  input  logic [ADDR_W-1:0] byte_addr_i,
  input  logic [31:0]       write_data_i,
  input  logic [7:0]        spi_rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [31:0]       read_data_o,
  output logic              spi_tx_valid_o,
  output logic [7:0]        spi_tx_byte_o,
  output logic [7:0]        select_lines_n_o,
  output logic              irq_out_o,
  output logic              bad_access_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [3:0]        cfg_data_i
);

  item_t            front_item, q_item;
  q_stat_t          q_stat;
  logic             q_push, q_pop;
  logic [3:0]       select_count_q;
  logic [RX_LW-1:0] rx_level;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      select_count_q <= SEL_COUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      select_count_q <= cfg_data_i;
    end
  end

  assign in_stall_o = q_stat.full;
  assign q_push     = in_valid_i && !in_stall_o;

  scrb_front u_front (
    .req_type_i    (req_type_i),
    .byte_addr_i   (byte_addr_i),
    .write_data_i  (write_data_i),
    .spi_rx_byte_i (spi_rx_byte_i),
    .item_o        (front_item)
  );

  scrb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (front_item),
    .pop_i  (q_pop),
    .item_o (q_item),
    .stat_o (q_stat)
  );

  scrb_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (q_item),
    .q_stat_i         (q_stat),
    .pop_o            (q_pop),
    .select_count_i   (select_count_q),
    .rx_level_o       (rx_level),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .read_data_o      (read_data_o),
    .spi_tx_valid_o   (spi_tx_valid_o),
    .spi_tx_byte_o    (spi_tx_byte_o),
    .select_lines_n_o (select_lines_n_o),
    .irq_out_o        (irq_out_o),
    .bad_access_o     (bad_access_o)
  );

  // FIFO fill never passes its depth
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_level <= RX_LW'(RX_DEPTH))
    else $error("receive level beyond depth");

  // a rejected offset has no side effects in its result
  a_bad_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_access_o |-> (read_data_o == '0) && !spi_tx_valid_o)
    else $error("bad access produced data");

  // no shifted byte means no byte value
  a_tx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !spi_tx_valid_o |-> spi_tx_byte_o == '0)
    else $error("tx byte without tx valid");

  // an empty queue never stalls the input
  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_stat.nonempty |-> !in_stall_o)
    else $error("stall with empty queue");

  // the back end only pops items that exist
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_stat.nonempty)
    else $error("pop from empty queue");

endmodule
